// ===== design/vmblk_pkg.sv =====
// shared types, register offsets and constants of the virtio-mmio block register file
package vmblk_pkg;

    localparam int QUEUE_SIZE_MAX = 64;
    localparam int QLEN_W         = $clog2(QUEUE_SIZE_MAX + 1);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 240;
    localparam int CFG_W     = 48;
    localparam int CAP_W     = 48;

    localparam logic [31:0] MAGIC_VALUE  = 32'h7472_6976;
    localparam logic [31:0] VENDOR_VALUE = 32'h5853_5959;
    localparam logic [31:0] MMIO_VERSION = 32'd2;
    localparam logic [31:0] BLK_DEV_ID   = 32'd2;
    localparam logic [31:0] STAT_FEAT_OK = 32'h0000_0008;
    localparam logic [31:0] SECTOR_BYTES = 32'd512;
    localparam logic [31:0] INT_USED     = 32'h0000_0001;
    localparam logic [31:0] FEAT_WORD0   = 32'h1000_0240;
    localparam logic [31:0] FEAT_WORD1   = 32'h0000_0001;

    // register offsets in the 4 KiB window
    localparam logic [11:0] OFF_MAGIC      = 12'h000;
    localparam logic [11:0] OFF_VERSION    = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID  = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID  = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT   = 12'h010;
    localparam logic [11:0] OFF_DEV_FSEL   = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT   = 12'h020;
    localparam logic [11:0] OFF_DRV_FSEL   = 12'h024;
    localparam logic [11:0] OFF_QSEL       = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX  = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM  = 12'h038;
    localparam logic [11:0] OFF_QUEUE_RDY  = 12'h044;
    localparam logic [11:0] OFF_NOTIFY     = 12'h050;
    localparam logic [11:0] OFF_INT_STAT   = 12'h060;
    localparam logic [11:0] OFF_INT_ACK    = 12'h064;
    localparam logic [11:0] OFF_STATUS     = 12'h070;
    localparam logic [11:0] OFF_DESC_LO    = 12'h080;
    localparam logic [11:0] OFF_DESC_HI    = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO   = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI   = 12'h094;
    localparam logic [11:0] OFF_USED_LO    = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI    = 12'h0a4;
    localparam logic [11:0] OFF_CFG_GEN    = 12'h0fc;
    localparam logic [11:0] OFF_CAP_LO     = 12'h100;
    localparam logic [11:0] OFF_CAP_HI     = 12'h104;
    localparam logic [11:0] OFF_BLK_SIZE   = 12'h114;

    // configuration register indexes
    localparam logic CFG_DISK_PRESENT = 1'b0;
    localparam logic CFG_CAPACITY     = 1'b1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_USED  = 2'd2
    } vmblk_cmd_t;

    typedef struct packed {
        vmblk_cmd_t  cmd;
        logic [11:0] reg_offset;
        logic [31:0] write_data;
        logic        no_interrupt;
    } vmblk_req_t;

    typedef struct packed {
        logic [31:0]       read_data;
        logic              irq_line;
        logic              notify_pulse;
        logic              queue_enabled;
        logic [QLEN_W-1:0] queue_length;
        logic [63:0]       desc_ring_base;
        logic [63:0]       avail_ring_base;
        logic [63:0]       used_ring_base;
    } vmblk_result_t;

    function automatic logic [31:0] offered_features(input logic [31:0] sel);
        logic [31:0] f;
        f = 32'd0;
        if (sel == 32'd0) f = FEAT_WORD0;
        else if (sel == 32'd1) f = FEAT_WORD1;
        return f;
    endfunction

endpackage

// ===== design/vmblk_core.sv =====
// device register state, access decode and per-transfer update
module vmblk_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  vmblk_pkg::vmblk_req_t    req,
    input  logic                     disk_present,
    input  logic [vmblk_pkg::CAP_W-1:0] capacity_sectors,
    output vmblk_pkg::vmblk_result_t result
);
    import vmblk_pkg::*;

    logic [31:0]       dev_fsel_reg, dev_fsel_next;
    logic [31:0]       drv_fsel_reg, drv_fsel_next;
    logic [31:0]       drv_feat_reg [2];
    logic [31:0]       drv_feat_next [2];
    logic [31:0]       qsel_reg, qsel_next;
    logic [QLEN_W-1:0] queue_size_reg, queue_size_next;
    logic              queue_ready_reg, queue_ready_next;
    logic [63:0]       desc_addr_reg, desc_addr_next;
    logic [63:0]       avail_addr_reg, avail_addr_next;
    logic [63:0]       used_addr_reg, used_addr_next;
    logic              irq_status_reg, irq_status_next;
    logic [31:0]       dev_status_reg, dev_status_next;

    logic [31:0] rd;
    logic        pulse;
    logic        q0;
    logic        bad_feat;
    logic [31:0] v;

    assign q0 = (qsel_reg == 32'd0);
    assign v  = req.write_data;
    assign bad_feat = ((drv_feat_reg[0] & ~offered_features(32'd0)) != 32'd0) ||
                      ((drv_feat_reg[1] & ~offered_features(32'd1)) != 32'd0);

    always_comb begin
        dev_fsel_next    = dev_fsel_reg;
        drv_fsel_next    = drv_fsel_reg;
        drv_feat_next[0] = drv_feat_reg[0];
        drv_feat_next[1] = drv_feat_reg[1];
        qsel_next        = qsel_reg;
        queue_size_next  = queue_size_reg;
        queue_ready_next = queue_ready_reg;
        desc_addr_next   = desc_addr_reg;
        avail_addr_next  = avail_addr_reg;
        used_addr_next   = used_addr_reg;
        irq_status_next  = irq_status_reg;
        dev_status_next  = dev_status_reg;
        rd    = 32'd0;
        pulse = 1'b0;

        case (req.cmd)
            CMD_READ: begin
                case (req.reg_offset)
                    OFF_MAGIC:     rd = MAGIC_VALUE;
                    OFF_VERSION:   rd = MMIO_VERSION;
                    OFF_DEVICE_ID: rd = disk_present ? BLK_DEV_ID : 32'd0;
                    OFF_VENDOR_ID: rd = VENDOR_VALUE;
                    OFF_DEV_FEAT:  rd = offered_features(dev_fsel_reg);
                    OFF_DEV_FSEL:  rd = dev_fsel_reg;
                    OFF_DRV_FSEL:  rd = drv_fsel_reg;
                    OFF_QSEL:      rd = qsel_reg;
                    OFF_QUEUE_MAX: rd = q0 ? 32'(QUEUE_SIZE_MAX) : 32'd0;
                    OFF_QUEUE_NUM: rd = 32'(queue_size_reg);
                    OFF_QUEUE_RDY: rd = {31'd0, queue_ready_reg};
                    OFF_INT_STAT:  rd = {31'd0, irq_status_reg};
                    OFF_STATUS:    rd = dev_status_reg;
                    OFF_DESC_LO:   rd = desc_addr_reg[31:0];
                    OFF_DESC_HI:   rd = desc_addr_reg[63:32];
                    OFF_AVAIL_LO:  rd = avail_addr_reg[31:0];
                    OFF_AVAIL_HI:  rd = avail_addr_reg[63:32];
                    OFF_USED_LO:   rd = used_addr_reg[31:0];
                    OFF_USED_HI:   rd = used_addr_reg[63:32];
                    OFF_CFG_GEN:   rd = 32'd0;
                    OFF_CAP_LO:    rd = capacity_sectors[31:0];
                    OFF_CAP_HI:    rd = 32'(capacity_sectors[CAP_W-1:32]);
                    OFF_BLK_SIZE:  rd = SECTOR_BYTES;
                    default:       rd = 32'd0;
                endcase
            end
            CMD_WRITE: begin
                case (req.reg_offset)
                    OFF_DEV_FSEL: dev_fsel_next = v;
                    OFF_DRV_FEAT: begin
                        if (drv_fsel_reg < 32'd2) drv_feat_next[drv_fsel_reg[0]] = v;
                    end
                    OFF_DRV_FSEL: drv_fsel_next = v;
                    OFF_QSEL:     qsel_next = v;
                    OFF_QUEUE_NUM: begin
                        if (q0) begin
                            queue_size_next = (v <= 32'(QUEUE_SIZE_MAX)) ? v[QLEN_W-1:0]
                                                                         : QLEN_W'(QUEUE_SIZE_MAX);
                        end
                    end
                    OFF_QUEUE_RDY: if (q0) queue_ready_next = v[0];
                    OFF_NOTIFY:    pulse = (v == 32'd0);
                    OFF_INT_ACK:   if ((v & INT_USED) != 32'd0) irq_status_next = 1'b0;
                    OFF_STATUS: begin
                        if (v == 32'd0) begin
                            // device reset: everything back to power-up values
                            dev_fsel_next    = 32'd0;
                            drv_fsel_next    = 32'd0;
                            drv_feat_next[0] = 32'd0;
                            drv_feat_next[1] = 32'd0;
                            qsel_next        = 32'd0;
                            queue_size_next  = '0;
                            queue_ready_next = 1'b0;
                            desc_addr_next   = 64'd0;
                            avail_addr_next  = 64'd0;
                            used_addr_next   = 64'd0;
                            irq_status_next  = 1'b0;
                            dev_status_next  = 32'd0;
                        end else if (((v & STAT_FEAT_OK) != 32'd0) && bad_feat) begin
                            dev_status_next = v & ~STAT_FEAT_OK;
                        end else begin
                            dev_status_next = v;
                        end
                    end
                    OFF_DESC_LO:  if (q0) desc_addr_next[31:0]   = v;
                    OFF_DESC_HI:  if (q0) desc_addr_next[63:32]  = v;
                    OFF_AVAIL_LO: if (q0) avail_addr_next[31:0]  = v;
                    OFF_AVAIL_HI: if (q0) avail_addr_next[63:32] = v;
                    OFF_USED_LO:  if (q0) used_addr_next[31:0]   = v;
                    OFF_USED_HI:  if (q0) used_addr_next[63:32]  = v;
                    default: ;
                endcase
            end
            CMD_USED: begin
                if (!req.no_interrupt) irq_status_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_fsel_reg    <= 32'd0;
            drv_fsel_reg    <= 32'd0;
            drv_feat_reg[0] <= 32'd0;
            drv_feat_reg[1] <= 32'd0;
            qsel_reg        <= 32'd0;
            queue_size_reg  <= '0;
            queue_ready_reg <= 1'b0;
            desc_addr_reg   <= 64'd0;
            avail_addr_reg  <= 64'd0;
            used_addr_reg   <= 64'd0;
            irq_status_reg  <= 1'b0;
            dev_status_reg  <= 32'd0;
        end else if (fire) begin
            dev_fsel_reg    <= dev_fsel_next;
            drv_fsel_reg    <= drv_fsel_next;
            drv_feat_reg[0] <= drv_feat_next[0];
            drv_feat_reg[1] <= drv_feat_next[1];
            qsel_reg        <= qsel_next;
            queue_size_reg  <= queue_size_next;
            queue_ready_reg <= queue_ready_next;
            desc_addr_reg   <= desc_addr_next;
            avail_addr_reg  <= avail_addr_next;
            used_addr_reg   <= used_addr_next;
            irq_status_reg  <= irq_status_next;
            dev_status_reg  <= dev_status_next;
        end
    end

    // result reflects the state after this transfer
    always_comb begin
        result.read_data       = rd;
        result.irq_line        = irq_status_next;
        result.notify_pulse    = pulse;
        result.queue_enabled   = queue_ready_next;
        result.queue_length    = queue_size_next;
        result.desc_ring_base  = desc_addr_next;
        result.avail_ring_base = avail_addr_next;
        result.used_ring_base  = used_addr_next;
    end

endmodule

// ===== design/virtio_mmio_block_register_file_top.sv =====
// Register file of a minimal version-2 virtio-mmio block device with one queue.
//
// Input stream: one register access or queue-engine event per transfer.
//   s_axis_tuser carries the command (read, write, used-buffer completion);
//   s_axis_tdata carries offset, write data and the no-interrupt flag.
// Output stream: exactly one result per input transfer, holding the read
//   data, interrupt line, notify pulse and the current queue setup.
// Configuration: cfg_we/cfg_index/cfg_wdata write disk_present (index 0)
//   and capacity_sectors (index 1).
//
// The device state updates at the input transfer and the result sits in the
// output register on the next cycle. Throughput is one transfer per cycle
// while the receiver does not stall; decode and update are single-level logic
// between the input handshake and the output register.
// While the receiver stalls, the output register holds its result and the
// input stalls too; s_axis_tready is high whenever the output register is
// empty or being drained in the same cycle.
// Synchronous reset clears all device registers, the configuration
// registers and the output valid flag.
module virtio_mmio_block_register_file_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // reg_offset[11:0], write_data[43:12], no_interrupt[44], zero pad
    input  logic [vmblk_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data[31:0], irq_line[32], notify_pulse[33], queue_enabled[34],
    // queue_length[41:35], desc_ring_base[105:42], avail_ring_base[169:106],
    // used_ring_base[233:170], zero pad
    output logic [vmblk_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [vmblk_pkg::CFG_W-1:0]       cfg_wdata
);
    import vmblk_pkg::*;

    localparam int RES_W = $bits(vmblk_result_t);

    logic                 disk_present_reg;
    logic [CAP_W-1:0]     capacity_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic                 fire;
    vmblk_req_t           req;
    vmblk_result_t        result;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    assign req.cmd          = vmblk_cmd_t'(s_axis_tuser);
    assign req.reg_offset   = s_axis_tdata[11:0];
    assign req.write_data   = s_axis_tdata[43:12];
    assign req.no_interrupt = s_axis_tdata[44];

    vmblk_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .fire             (fire),
        .req              (req),
        .disk_present     (disk_present_reg),
        .capacity_sectors (capacity_reg),
        .result           (result)
    );

    always_comb begin
        m_data_next = '0;
        m_data_next[31:0]    = result.read_data;
        m_data_next[32]      = result.irq_line;
        m_data_next[33]      = result.notify_pulse;
        m_data_next[34]      = result.queue_enabled;
        m_data_next[41:35]   = result.queue_length;
        m_data_next[105:42]  = result.desc_ring_base;
        m_data_next[169:106] = result.avail_ring_base;
        m_data_next[233:170] = result.used_ring_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_present_reg <= 1'b0;
            capacity_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DISK_PRESENT: disk_present_reg <= cfg_wdata[0];
                CFG_CAPACITY:     capacity_reg     <= cfg_wdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // result struct must fit the packed output word
    if (RES_W > M_TDATA_W) begin : g_width_check
        $error("result wider than output bus");
    end

endmodule

// ===== design/vmblk_checker.sv =====
// port-level checks of the register file, bound to the top level
module vmblk_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [vmblk_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [vmblk_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import vmblk_pkg::*;

    logic s_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;

    // a stalled result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // every input transfer shows up as a result in the next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_axis_tvalid)
        else $error("result missing after input transfer");

    // only reads return data
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_axis_tuser != CMD_READ) |=> m_axis_tdata[31:0] == 32'd0)
        else $error("nonzero read data for non-read transfer");

    // status write of zero clears interrupt and queue setup
    a_dev_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && (s_axis_tuser == CMD_WRITE) && (s_axis_tdata[11:0] == OFF_STATUS) &&
        (s_axis_tdata[43:12] == 32'd0)
        |=> !m_axis_tdata[32] && !m_axis_tdata[34] && (m_axis_tdata[41:35] == 7'd0))
        else $error("device reset left state behind");

endmodule

bind virtio_mmio_block_register_file_top vmblk_checker u_vmblk_checker (.*);
